[design/tapd_pkg.sv]
// ----------------------------------------------------------------------------
// tapd_pkg
// Shared types, constants and helper functions for the tape pulse decoder.
// ----------------------------------------------------------------------------
package tapd_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KindByte = 2'd0,
      KindEnd  = 2'd1,
      KindRate = 2'd2
   } kind_type;

   localparam logic [7:0]  AmpReset   = 8'd40;
   localparam logic [6:0]  RatePulses = 7'd100;

   // rate = sum * 44100 / 1342 = sum * 22050 / 671
   localparam logic [14:0] RateNum    = 15'd22050;
   localparam logic [9:0]  RateDen    = 10'd671;
   // floor(2^40 / 671)
   localparam logic [30:0] RateRecip  = 31'd1638616434;
   localparam logic [28:0] RateMax    = '1;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [23:0] byte_count;
      logic        name_end;
      logic [15:0] suspicious_count;
   } result_type;

   // load enables of the rate scaling stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   // floor(amp * 70 / 100) = floor(amp * 7 / 10); y * 6554 >> 16 is exact for y < 16384
   function automatic logic [7:0] min_amp_of(input logic [7:0] amp);
      logic [10:0] y;
      logic [23:0] p;
      y = 11'(amp) * 11'd7;
      p = 24'(y) * 24'd6554;
      return p[23:16];
   endfunction

endpackage

[design/tapd_if.sv]
// ----------------------------------------------------------------------------
// tapd channel interfaces
// Valid/ready channels for requests, responses and the amplitude register.
// ----------------------------------------------------------------------------
interface tapd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       new_recording;

   modport source (output valid, output sample, output new_recording, input ready);
   modport sink   (input valid, input sample, input new_recording, output ready);
endinterface

interface tapd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  byte_value;
   logic [23:0] byte_count;
   logic        name_end;
   logic [15:0] suspicious_count;
   logic [28:0] rate_hz;

   modport source (output valid, output kind, output byte_value, output byte_count,
                   output name_end, output suspicious_count, output rate_hz, input ready);
   modport sink   (input valid, input kind, input byte_value, input byte_count,
                   input name_end, input suspicious_count, input rate_hz, output ready);
endinterface

interface tapd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] expected_amplitude;

   modport source (output valid, output expected_amplitude, input ready);
   modport sink   (input valid, input expected_amplitude, output ready);
endinterface

[design/tapd_decode.sv]
// ----------------------------------------------------------------------------
// tapd_decode
// Pulse phase tracking, bit and byte assembly and pulse length summing.
// ----------------------------------------------------------------------------
module tapd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 amp_write,
   input  logic [7:0]           amp_data,
   input  logic                 fire,
   input  logic [7:0]           sample,
   input  logic                 new_recording,
   output logic                 has_result,
   output tapd_pkg::result_type result,
   output logic [23:0]          length_sum
);
   import tapd_pkg::*;

   logic        started_ff, started_in;
   logic        stopped_ff, stopped_in;
   logic        falling_ff, falling_in;
   logic [7:0]  prev_ff, prev_in;
   logic [7:0]  peak_ff, peak_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] rise_start_ff, rise_start_in;
   logic [31:0] fall_start_ff, fall_start_in;
   logic        any_pulse_ff, any_pulse_in;
   logic [7:0]  pulses_ff, pulses_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  bit_idx_ff, bit_idx_in;
   logic [23:0] bytes_ff, bytes_in;
   logic        name_seen_ff, name_seen_in;
   logic [23:0] lsum_ff, lsum_in;
   logic [6:0]  lcount_ff, lcount_in;
   logic [15:0] susp_ff, susp_in;
   logic [7:0]  min_amp_ff;

   logic [31:0] pos_next;
   logic [31:0] rise_diff, fall_diff;
   logic [15:0] rise_len, fall_len;
   logic [17:0] fall_len3;
   logic        amp_ok;
   logic        boundary;
   logic        bit_val;
   logic [7:0]  shift_next;
   logic [24:0] lsum_wide;
   logic [6:0]  lcount_next;

   always_comb begin
      pos_next   = pos_ff + 32'd1;
      rise_diff  = fall_start_ff - rise_start_ff;
      fall_diff  = pos_next - fall_start_ff;
      rise_len   = (|rise_diff[31:16]) ? 16'hFFFF : rise_diff[15:0];
      fall_len   = (|fall_diff[31:16]) ? 16'hFFFF : fall_diff[15:0];
      fall_len3  = {2'b00, fall_len} + {1'b0, fall_len, 1'b0};
      amp_ok     = {1'b0, peak_ff} >= ({1'b0, prev_ff} + {1'b0, min_amp_ff});
      boundary   = ({2'b00, rise_len} > fall_len3) && any_pulse_ff;
      lsum_wide  = {1'b0, lsum_ff} + 25'(rise_len) + 25'(fall_len);
      lcount_next = lcount_ff + 7'd1;
      bit_val    = 1'b0;
      shift_next = shift_ff;

      started_in    = started_ff;
      stopped_in    = stopped_ff;
      falling_in    = falling_ff;
      prev_in       = prev_ff;
      peak_in       = peak_ff;
      pos_in        = pos_ff;
      rise_start_in = rise_start_ff;
      fall_start_in = fall_start_ff;
      any_pulse_in  = any_pulse_ff;
      pulses_in     = pulses_ff;
      shift_in      = shift_ff;
      bit_idx_in    = bit_idx_ff;
      bytes_in      = bytes_ff;
      name_seen_in  = name_seen_ff;
      lsum_in       = lsum_ff;
      lcount_in     = lcount_ff;
      susp_in       = susp_ff;

      has_result              = 1'b0;
      result.kind             = KindByte;
      result.byte_value       = 8'd0;
      result.byte_count       = bytes_ff;
      result.name_end         = 1'b0;
      result.suspicious_count = susp_ff;

      if (fire) begin
         if (new_recording) begin
            // start over: this sample only seeds the previous sample
            started_in    = 1'b1;
            stopped_in    = 1'b0;
            falling_in    = 1'b0;
            prev_in       = sample;
            peak_in       = 8'd0;
            pos_in        = 32'd0;
            rise_start_in = 32'd0;
            fall_start_in = 32'd0;
            any_pulse_in  = 1'b0;
            pulses_in     = 8'd0;
            shift_in      = 8'd0;
            bit_idx_in    = 3'd0;
            bytes_in      = 24'd0;
            name_seen_in  = 1'b0;
            lsum_in       = 24'd0;
            lcount_in     = 7'd0;
            susp_in       = 16'd0;
         end else if (started_ff && !stopped_ff) begin
            pos_in  = pos_next;
            prev_in = sample;
            if (!falling_ff) begin
               if (sample < prev_ff) begin
                  peak_in       = prev_ff;
                  falling_in    = 1'b1;
                  fall_start_in = pos_next;
               end
            end else if (sample > prev_ff) begin
               falling_in = 1'b0;
               if (amp_ok) begin
                  rise_start_in = pos_next;
                  if (boundary) begin
                     if (pulses_ff == 8'd1) begin
                        // end of program: freeze until the next recording
                        stopped_in  = 1'b1;
                        has_result  = 1'b1;
                        result.kind = KindEnd;
                     end else begin
                        case (pulses_ff)
                           8'd4:       bit_val = 1'b0;
                           8'd8, 8'd9: bit_val = 1'b1;
                           default: begin
                              bit_val = 1'b0;
                              if (susp_ff != 16'hFFFF) begin
                                 susp_in = susp_ff + 16'd1;
                              end
                           end
                        endcase
                        shift_next = {shift_ff[6:0], bit_val};
                        shift_in   = shift_next;
                        bit_idx_in = bit_idx_ff + 3'd1;
                        if (bit_idx_ff == 3'd7) begin
                           if (bytes_ff != 24'hFFFFFF) begin
                              bytes_in = bytes_ff + 24'd1;
                           end
                           has_result        = 1'b1;
                           result.kind       = KindByte;
                           result.byte_value = shift_next;
                           result.byte_count = bytes_in;
                           result.name_end   = !name_seen_ff && shift_next[7];
                           if (shift_next[7]) begin
                              name_seen_in = 1'b1;
                           end
                           shift_in = 8'd0;
                        end
                        result.suspicious_count = susp_in;
                        pulses_in    = 8'd1;
                        any_pulse_in = 1'b1;
                     end
                  end else begin
                     if (bytes_ff != 24'd0 && lcount_ff < RatePulses) begin
                        lsum_in   = lsum_wide[24] ? 24'hFFFFFF : lsum_wide[23:0];
                        lcount_in = lcount_next;
                        if (lcount_next == RatePulses) begin
                           has_result  = 1'b1;
                           result.kind = KindRate;
                        end
                     end
                     if (pulses_ff != 8'hFF) begin
                        pulses_in = pulses_ff + 8'd1;
                     end
                     any_pulse_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign length_sum = lsum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_amp_ff    <= min_amp_of(AmpReset);
         started_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         falling_ff    <= 1'b0;
         prev_ff       <= 8'd0;
         peak_ff       <= 8'd0;
         pos_ff        <= 32'd0;
         rise_start_ff <= 32'd0;
         fall_start_ff <= 32'd0;
         any_pulse_ff  <= 1'b0;
         pulses_ff     <= 8'd0;
         shift_ff      <= 8'd0;
         bit_idx_ff    <= 3'd0;
         bytes_ff      <= 24'd0;
         name_seen_ff  <= 1'b0;
         lsum_ff       <= 24'd0;
         lcount_ff     <= 7'd0;
         susp_ff       <= 16'd0;
      end else begin
         if (amp_write) begin
            min_amp_ff <= min_amp_of(amp_data);
         end
         started_ff    <= started_in;
         stopped_ff    <= stopped_in;
         falling_ff    <= falling_in;
         prev_ff       <= prev_in;
         peak_ff       <= peak_in;
         pos_ff        <= pos_in;
         rise_start_ff <= rise_start_in;
         fall_start_ff <= fall_start_in;
         any_pulse_ff  <= any_pulse_in;
         pulses_ff     <= pulses_in;
         shift_ff      <= shift_in;
         bit_idx_ff    <= bit_idx_in;
         bytes_ff      <= bytes_in;
         name_seen_ff  <= name_seen_in;
         lsum_ff       <= lsum_in;
         lcount_ff     <= lcount_in;
         susp_ff       <= susp_in;
      end
   end

endmodule

[design/tapd_rate_scale.sv]
// ----------------------------------------------------------------------------
// tapd_rate_scale
// Four-stage constant scaling of the pulse length sum into a sample rate.
// ----------------------------------------------------------------------------
module tapd_rate_scale (
   input  logic                   clock,
   input  tapd_pkg::stage_en_type en,
   input  logic [23:0]            length_sum,
   input  logic                   use_rate,
   output logic [28:0]            rate_hz
);
   import tapd_pkg::*;

   logic [38:0] prod_ff;
   logic [38:0] prod_mid_ff;
   logic [38:0] prod_end_ff;
   logic [49:0] part_hi_ff;
   logic [50:0] part_lo_ff;
   logic [29:0] quot_ff;
   logic [28:0] rate_ff;

   logic [49:0] quot_sum;
   logic [39:0] back;
   logic [10:0] rem;
   logic [29:0] quot_fix;

   always_comb begin
      // estimate may be one low; fix with a single compare
      quot_sum = part_hi_ff + 50'(part_lo_ff[50:20]);
      back     = 40'(quot_ff) * 40'(RateDen);
      rem      = 11'({1'b0, prod_end_ff} - back);
      quot_fix = quot_ff + 30'(rem >= 11'(RateDen));
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         prod_ff <= 39'(length_sum) * 39'(RateNum);
      end
      if (en.s3) begin
         part_hi_ff  <= 50'(prod_ff[38:20]) * 50'(RateRecip);
         part_lo_ff  <= 51'(prod_ff[19:0]) * 51'(RateRecip);
         prod_mid_ff <= prod_ff;
      end
      if (en.s4) begin
         quot_ff     <= quot_sum[49:20];
         prod_end_ff <= prod_mid_ff;
      end
      if (en.s5) begin
         if (!use_rate) begin
            rate_ff <= '0;
         end else if (quot_fix > 30'(RateMax)) begin
            rate_ff <= RateMax;
         end else begin
            rate_ff <= quot_fix[28:0];
         end
      end
   end

   assign rate_hz = rate_ff;

endmodule

[design/tape_audio_pulse_bit_decoder_top.sv]
// ----------------------------------------------------------------------------
// tape_audio_pulse_bit_decoder_top
// Decodes tape audio samples into bytes, end markers and a rate estimate.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                                   handshake
//   req_ch   in         sample, new_recording                     valid/ready
//   rsp_ch   out        kind, byte_value, byte_count, name_end,   valid/ready
//                       suspicious_count, rate_hz
//   csr_ch   in         expected_amplitude                        valid/ready
//
// One request per cycle is taken while stage 0 is free; the decoder state updates once per request.
// A response reaches the output register through the input register, the decode step
// and four rate scaling stages.
// Requests that produce no response drop out after the decode step.
// Each stage moves when the next one is free, so bubbles collapse and a stalled
// response only blocks requests once all six stages are full.
// Synchronous reset clears the decoder state and loads the amplitude register from a setting of 40.
// The amplitude register takes a write in every cycle.
//
module tape_audio_pulse_bit_decoder_top (
   input  logic clock,
   input  logic reset,
   tapd_req_if.sink   req_ch,
   tapd_rsp_if.source rsp_ch,
   tapd_csr_if.sink   csr_ch
);
   import tapd_pkg::*;

   // stage 0 holds the raw request, stages 1 to 5 hold responses
   logic [5:0]  valid_ff, valid_in;
   logic [5:0]  free;
   logic [5:0]  load;
   logic [7:0]  sample_ff;
   logic        new_rec_ff;
   result_type  rec_ff [1:5];
   logic [23:0] lsum_ff;

   logic         fire;
   logic         has_result;
   result_type   dec_result;
   logic [23:0]  dec_lsum;
   stage_en_type stage_en;
   logic [28:0]  rate_hz;

   // free[i]: stage i can take a new entry this cycle
   always_comb begin
      free[5] = !valid_ff[5] || rsp_ch.ready;
      for (int i = 4; i >= 0; i--) begin
         free[i] = !valid_ff[i] || free[i+1];
      end
      fire    = valid_ff[0] && free[1];
      load[0] = req_ch.valid && free[0];
      load[1] = fire && has_result;
      for (int i = 2; i <= 5; i++) begin
         load[i] = valid_ff[i-1] && free[i];
      end
      for (int i = 0; i <= 4; i++) begin
         valid_in[i] = load[i] || (valid_ff[i] && !free[i+1]);
      end
      valid_in[5] = load[5] || (valid_ff[5] && !rsp_ch.ready);
   end

   assign req_ch.ready = free[0];
   assign csr_ch.ready = 1'b1;

   tapd_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .amp_write     (csr_ch.valid),
      .amp_data      (csr_ch.expected_amplitude),
      .fire          (fire),
      .sample        (sample_ff),
      .new_recording (new_rec_ff),
      .has_result    (has_result),
      .result        (dec_result),
      .length_sum    (dec_lsum)
   );

   assign stage_en.s2 = load[2];
   assign stage_en.s3 = load[3];
   assign stage_en.s4 = load[4];
   assign stage_en.s5 = load[5];

   tapd_rate_scale u_rate (
      .clock      (clock),
      .en         (stage_en),
      .length_sum (lsum_ff),
      .use_rate   (rec_ff[4].kind == KindRate),
      .rate_hz    (rate_hz)
   );

   // hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (load[0]) begin
         sample_ff  <= req_ch.sample;
         new_rec_ff <= req_ch.new_recording;
      end
      if (load[1]) begin
         rec_ff[1] <= dec_result;
         lsum_ff   <= dec_lsum;
      end
      for (int i = 2; i <= 5; i++) begin
         if (load[i]) begin
            rec_ff[i] <= rec_ff[i-1];
         end
      end
   end

   assign rsp_ch.valid            = valid_ff[5];
   assign rsp_ch.kind             = rec_ff[5].kind;
   assign rsp_ch.byte_value       = rec_ff[5].byte_value;
   assign rsp_ch.byte_count       = rec_ff[5].byte_count;
   assign rsp_ch.name_end         = rec_ff[5].name_end;
   assign rsp_ch.suspicious_count = rec_ff[5].suspicious_count;
   assign rsp_ch.rate_hz          = rate_hz;

`ifndef SYNTH
   a_name_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.name_end |->
         rsp_ch.kind == KindByte && rsp_ch.byte_value[7])
      else $error("name end flagged on a non-byte or a byte without bit 7");

   a_rate_only_on_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind != KindRate |-> rsp_ch.rate_hz == '0)
      else $error("rate estimate leaked into another response kind");

   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind == KindEnd |->
         rsp_ch.byte_value == '0 && rsp_ch.name_end == 1'b0)
      else $error("end marker carries byte data");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> &valid_ff)
      else $error("request stalled while a stage is empty");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !free[1] |=> valid_ff[0] && $stable(sample_ff))
      else $error("blocked request lost from the input register");
`endif

endmodule

[verif/tb_tape_audio_pulse_bit_decoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tape_audio_pulse_bit_decoder_top
// Synthesizes tape pulse trains, predicts decoded bytes, end markers and the
// rate estimate in step with accepted requests, and checks every response.
// ----------------------------------------------------------------------------
module tb_tape_audio_pulse_bit_decoder_top;
   import tapd_pkg::*;

   localparam int  HALF_PERIOD     = 4;
   localparam int  RESET_CYCLES    = 5;
   localparam int  WATCHDOG_LIMIT  = 4000;
   localparam int  HOLD_CYCLES     = 300;
   localparam int  DRAIN_CYCLES    = 12;
   localparam int  PULSES_PER_RATE = 100;
   localparam int  AMP_AT_RESET    = 40;
   localparam int  LONG_RUN        = 66000;

   typedef struct packed {
      logic       new_recording;
      logic [7:0] sample;
   } sample_req_t;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [23:0] byte_count;
      logic        name_end;
      logic [15:0] suspicious_count;
      logic [28:0] rate_hz;
   } decoded_t;

   logic clock;
   logic reset;

   tapd_req_if req_ch ();
   tapd_rsp_if rsp_ch ();
   tapd_csr_if csr_ch ();

   tape_audio_pulse_bit_decoder_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // request stream waiting to be offered, and decoded outputs still owed
   sample_req_t sample_queue[$];
   decoded_t    decode_queue[$];

   int items_pushed;
   int items_taken;
   int live_items;
   int results_predicted;
   int error_count;
   int idle_pct;
   int stall_pct;
   int hold_asked;
   int hold_seen;
   int hold_left;
   int quiet_cycles;

   // generator view of the amplitude register and the current pulse baseline
   int amp_setting;
   int gen_floor;
   int gen_base;

   // ---------------------------------------------------------------------------
   // Decoder prediction state
   // ---------------------------------------------------------------------------
   bit [7:0]  amp_reg = 8'(AMP_AT_RESET);
   bit        armed;
   bit        halted;
   bit        in_fall;
   bit [7:0]  last_smp;
   bit [7:0]  peak;
   bit [31:0] pos;
   bit [31:0] rise_at;
   bit [31:0] fall_at;
   bit        seen_pulse;
   bit [7:0]  pulse_cnt;
   bit [7:0]  shreg;
   bit [3:0]  nbits;
   bit [23:0] byte_total;
   bit        name_done;
   bit [23:0] len_sum;
   bit [6:0]  len_cnt;
   bit [15:0] susp_total;

   function automatic void clear_decoder();
      armed      = 1'b0;
      halted     = 1'b0;
      in_fall    = 1'b0;
      last_smp   = '0;
      peak       = '0;
      pos        = '0;
      rise_at    = '0;
      fall_at    = '0;
      seen_pulse = 1'b0;
      pulse_cnt  = '0;
      shreg      = '0;
      nbits      = '0;
      byte_total = '0;
      name_done  = 1'b0;
      len_sum    = '0;
      len_cnt    = '0;
      susp_total = '0;
   endfunction

   function automatic int span(input bit [31:0] from_pos, input bit [31:0] to_pos);
      bit [31:0] d;
      d = to_pos - from_pos;
      return (d > 32'd65535) ? 65535 : int'(d);
   endfunction

   // a qualified pulse ends at the current sample
   function automatic bit finish_pulse(output decoded_t r);
      int     rise_len;
      int     fall_len;
      int     total;
      longint scaled;
      bit     data_bit;
      bit     got;
      r        = '0;
      got      = 1'b0;
      rise_len = span(rise_at, fall_at);
      fall_len = span(fall_at, pos);
      rise_at  = pos;
      if (rise_len > fall_len * 3 && seen_pulse) begin
         data_bit = 1'b0;
         if (pulse_cnt == 8'd1) begin
            halted             = 1'b1;
            r.kind             = KindEnd;
            r.byte_count       = byte_total;
            r.suspicious_count = susp_total;
            return 1'b1;
         end else if (pulse_cnt == 8'd8 || pulse_cnt == 8'd9) begin
            data_bit = 1'b1;
         end else if (pulse_cnt != 8'd4 && susp_total != 16'hFFFF) begin
            susp_total++;
         end
         shreg = {shreg[6:0], data_bit};
         nbits++;
         if (nbits == 4'd8) begin
            if (byte_total != 24'hFFFFFF) byte_total++;
            r.kind             = KindByte;
            r.byte_value       = shreg;
            r.byte_count       = byte_total;
            r.name_end         = !name_done && shreg[7];
            r.suspicious_count = susp_total;
            if (shreg[7]) name_done = 1'b1;
            got   = 1'b1;
            shreg = '0;
            nbits = '0;
         end
         pulse_cnt = '0;
      end else if (byte_total != 0 && int'(len_cnt) < PULSES_PER_RATE) begin
         total   = int'(len_sum) + rise_len + fall_len;
         len_sum = (total > 24'hFFFFFF) ? 24'hFFFFFF : 24'(total);
         len_cnt++;
         if (int'(len_cnt) == PULSES_PER_RATE) begin
            scaled             = longint'(len_sum) * 44100 / 1342;
            r.kind             = KindRate;
            r.byte_count       = byte_total;
            r.suspicious_count = susp_total;
            r.rate_hz          = (scaled > 64'h1FFFFFFF) ? 29'h1FFFFFFF : 29'(scaled);
            got                = 1'b1;
         end
      end
      if (pulse_cnt != 8'd255) pulse_cnt++;
      seen_pulse = 1'b1;
      return got;
   endfunction

   function automatic bit decode_sample(input bit [7:0] smp, input bit nr,
                                        output decoded_t r);
      int fall_amp;
      int floor_amp;
      bit got;
      r   = '0;
      got = 1'b0;
      if (nr) begin
         clear_decoder();
         armed    = 1'b1;
         last_smp = smp;
      end else begin
         if (!armed || halted) return 1'b0;
         pos++;
      end
      if (!in_fall) begin
         if (smp < last_smp) begin
            peak    = last_smp;
            in_fall = 1'b1;
            fall_at = pos;
         end
      end else if (smp > last_smp) begin
         fall_amp  = int'(peak) - int'(last_smp);
         floor_amp = int'(amp_reg) * 70 / 100;
         in_fall   = 1'b0;
         if (fall_amp >= floor_amp) got = finish_pulse(r);
      end
      last_smp = smp;
      return got;
   endfunction

   // ---------------------------------------------------------------------------
   // Clock, driver, receiver, monitor and watchdog
   // ---------------------------------------------------------------------------
   always #HALF_PERIOD clock = ~clock;

   // Offer queued requests; predict each one as it is taken.
   always @(posedge clock) begin
      decoded_t    res;
      sample_req_t nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            items_taken++;
            if (decode_sample(req_ch.sample, req_ch.new_recording, res)) begin
               decode_queue.push_back(res);
               results_predicted++;
            end
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = sample_queue.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.sample        <= nxt.sample;
               req_ch.new_recording <= nxt.new_recording;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Drive response ready: a requested holdoff first, else random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t MISMATCH %s: expected %0d got %0d", $realtime, field, want, got);
      error_count++;
   endtask

   // Compare each taken response with the oldest owed output.
   always @(posedge clock) begin
      decoded_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (decode_queue.size() == 0) begin
            report_mismatch("response with none owed, kind", 0, rsp_ch.kind);
         end else begin
            want = decode_queue.pop_front();
            if (rsp_ch.kind != want.kind)
               report_mismatch("kind", want.kind, rsp_ch.kind);
            if (rsp_ch.byte_value != want.byte_value)
               report_mismatch("byte_value", want.byte_value, rsp_ch.byte_value);
            if (rsp_ch.byte_count != want.byte_count)
               report_mismatch("byte_count", want.byte_count, rsp_ch.byte_count);
            if (rsp_ch.name_end != want.name_end)
               report_mismatch("name_end", want.name_end, rsp_ch.name_end);
            if (rsp_ch.suspicious_count != want.suspicious_count)
               report_mismatch("suspicious_count", want.suspicious_count,
                               rsp_ch.suspicious_count);
            if (rsp_ch.rate_hz != want.rate_hz)
               report_mismatch("rate_hz", want.rate_hz, rsp_ch.rate_hz);
         end
      end
   end

   // Abort when no channel has moved anything for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_sample(input int s, input bit nr, input bit live);
      sample_req_t item;
      item.sample        = 8'(s);
      item.new_recording = nr;
      sample_queue.push_back(item);
      items_pushed++;
      if (live) live_items++;
   endtask

   task automatic write_amplitude(input int value);
      csr_ch.valid              <= 1'b1;
      csr_ch.expected_amplitude <= 8'(value);
      do @(posedge clock); while (!csr_ch.ready);
      amp_reg      = 8'(value);
      amp_setting  = value;
      gen_floor    = value * 70 / 100;
      csr_ch.valid <= 1'b0;
   endtask

   // Wait for every request to be taken and every output to arrive, then let
   // the pipeline flush requests that produce nothing.
   task automatic settle_down();
      while (items_taken != items_pushed || decode_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_amp();
      int lo;
      int hi;
      lo = (gen_floor > 6) ? gen_floor : 6;
      hi = 255 - gen_base;
      return (lo >= hi) ? hi : int'($urandom_range(hi, lo));
   endfunction

   task automatic new_base();
      int lo;
      lo       = (gen_floor > 6) ? gen_floor : 6;
      gen_base = $urandom_range(255 - lo, 0);
   endtask

   // Rise: gap flat samples just above base, then climb; fall back to base,
   // then hold the low level for extra samples.
   task automatic emit_pulse(input int gap, input int rise_n, input int fall_n,
                             input int amp, input int hold);
      int top;
      top = gen_base + amp;
      for (int i = 0; i < gap; i++) push_sample(gen_base + 1, 1'b0, 1'b1);
      for (int i = 1; i <= rise_n; i++)
         push_sample(gen_base + 1 + ((amp - 1) * i) / rise_n, 1'b0, 1'b1);
      for (int i = 1; i <= fall_n; i++)
         push_sample(top - (amp * i) / fall_n, 1'b0, 1'b1);
      for (int i = 0; i < hold; i++) push_sample(gen_base, 1'b0, 1'b1);
   endtask

   task automatic short_pulse();
      emit_pulse(0, $urandom_range(3, 1), $urandom_range(3, 1), pick_amp(), 0);
   endtask

   // rise longer than three falls marks a bit boundary
   task automatic boundary_pulse();
      int rise_n;
      int fall_n;
      rise_n = $urandom_range(3, 1);
      fall_n = $urandom_range(3, 1);
      emit_pulse(3 * fall_n - rise_n + 1 + $urandom_range(5, 0), rise_n, fall_n,
                 pick_amp(), 0);
   endtask

   task automatic emit_bit(input int pulses);
      boundary_pulse();
      for (int i = 1; i < pulses; i++) begin
         // drop in an undersized pulse now and then
         if (gen_floor >= 2 && $urandom_range(99) < 3)
            emit_pulse(0, 1, 1, $urandom_range(gen_floor - 1, 1), 0);
         short_pulse();
      end
   endtask

   task automatic emit_byte(input logic [7:0] value);
      int k;
      for (int b = 7; b >= 0; b--) begin
         k = value[b] ? int'($urandom_range(9, 8)) : 4;
         if ($urandom_range(99) < 4) begin
            do k = $urandom_range(12, 2); while (k == 4 || k == 8 || k == 9);
         end
         emit_bit(k);
      end
   endtask

   // two single-pulse bits: the second boundary sees a count of one
   task automatic emit_end_marker();
      boundary_pulse();
      boundary_pulse();
      push_sample(gen_base + 1, 1'b0, 1'b1);
      repeat ($urandom_range(4, 0)) push_sample($urandom_range(255, 0), 1'b0, 1'b0);
   endtask

   task automatic emit_recording(input int nbytes, input bit with_end);
      new_base();
      push_sample(gen_base, 1'b1, 1'b1);
      for (int i = 0; i < nbytes; i++) emit_byte(8'($urandom_range(255, 0)));
      if (with_end) begin
         emit_end_marker();
      end else begin
         boundary_pulse();
         push_sample(gen_base + 1, 1'b0, 1'b1);
      end
   endtask

   task automatic emit_noise(input int n);
      repeat (n) push_sample($urandom_range(255, 0), $urandom_range(99) < 3, 1'b1);
   endtask

   // Mostly well-formed recordings; some noise bursts and unfinished tapes.
   task automatic run_random(input int want_results, input int want_items);
      int res0;
      int items0;
      res0   = results_predicted;
      items0 = live_items;
      while (results_predicted - res0 < want_results || live_items - items0 < want_items)
      begin
         if ($urandom_range(9) == 0) emit_noise($urandom_range(40, 5));
         else emit_recording($urandom_range(7, 1), $urandom_range(3) != 0);
         wait (items_taken == items_pushed);
      end
   endtask

   task automatic directed_requests();
      // ignored before any recording
      push_sample(255, 1'b0, 1'b0);
      push_sample(0, 1'b0, 1'b0);
      // first pulse, then a long rise with a single pulse: end of program
      push_sample(0, 1'b1, 1'b1);
      push_sample(255, 1'b0, 1'b1);
      push_sample(0, 1'b0, 1'b1);
      repeat (6) push_sample(1, 1'b0, 1'b1);
      push_sample(200, 1'b0, 1'b1);
      push_sample(0, 1'b0, 1'b1);
      push_sample(5, 1'b0, 1'b1);
      // ignored after the end marker
      push_sample(128, 1'b0, 1'b0);
      push_sample(255, 1'b0, 1'b0);
      // restart at full scale; a fall too shallow is rejected
      push_sample(255, 1'b1, 1'b1);
      push_sample(254, 1'b0, 1'b1);
      push_sample(255, 1'b0, 1'b1);
      // restart again in the middle of a rise
      push_sample(0, 1'b1, 1'b1);
      push_sample(255, 1'b0, 1'b1);
   endtask

   // Saturate rise and fall lengths and the pulse count of one bit.
   task automatic long_recording();
      new_base();
      push_sample(gen_base, 1'b1, 1'b1);
      emit_byte(8'($urandom_range(255, 0)));
      emit_pulse(LONG_RUN, 2, 2, pick_amp(), 0);
      emit_pulse(0, 2, 1, pick_amp(), LONG_RUN);
      short_pulse();
      short_pulse();
      repeat (3) emit_byte(8'($urandom_range(255, 0)));
      emit_bit(260);
      emit_end_marker();
      wait (items_taken == items_pushed);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      clock                     = 1'b0;
      reset                     = 1'b1;
      req_ch.valid              = 1'b0;
      req_ch.sample             = '0;
      req_ch.new_recording      = 1'b0;
      rsp_ch.ready              = 1'b0;
      csr_ch.valid              = 1'b0;
      csr_ch.expected_amplitude = '0;
      amp_setting               = AMP_AT_RESET;
      gen_floor                 = AMP_AT_RESET * 70 / 100;
      gen_base                  = 0;
      idle_pct                  = 0;
      stall_pct                 = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset amplitude, no idling: directed, saturation, then random tapes
      directed_requests();
      long_recording();
      run_random(10, 150);

      // full-scale amplitude, sender mostly idle
      settle_down();
      write_amplitude(255);
      idle_pct = 82;
      run_random(10, 150);

      // zero amplitude accepts any fall; receiver mostly stalled
      settle_down();
      write_amplitude(0);
      idle_pct  = 0;
      stall_pct = 82;
      run_random(10, 150);

      // random amplitude, both sides idling
      settle_down();
      write_amplitude($urandom_range(254, 1));
      idle_pct  = 34;
      stall_pct = 34;
      run_random(10, 150);

      // hold the receiver off while short tapes pile up end markers
      settle_down();
      write_amplitude(100);
      idle_pct  = 0;
      stall_pct = 0;
      hold_asked++;
      repeat (10) begin
         new_base();
         push_sample(gen_base, 1'b1, 1'b1);
         emit_end_marker();
      end
      wait (items_taken == items_pushed);
      run_random(8, 100);

      // drain outstanding outputs, then allow for the pipeline depth
      while (items_taken != items_pushed || decode_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
